// ----- hw/rtl/bmhq_pkg.sv -----
// shared types, codes and default sizes for the binary min-heap queue
`timescale 1ns / 1ps
`default_nettype none

package bmhq_pkg;

   // default sizes
   localparam int CAPACITY_DEF    = 1024;
   localparam int KEY_BITS_DEF    = 16;
   localparam int HANDLE_BITS_DEF = 16;

   // fixed field widths
   localparam int OP_BITS     = 2;
   localparam int STATUS_BITS = 3;

   // request operations
   typedef enum logic [OP_BITS-1:0] {
      OP_INSERT = 2'd0,
      OP_POP    = 2'd1,
      OP_UPDATE = 2'd2,
      OP_NOP    = 2'd3
   } op_type;

   // response status codes
   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK        = 3'd0,
      ST_EMPTY     = 3'd1,
      ST_FULL      = 3'd2,
      ST_DROPPED   = 3'd3,
      ST_NOT_FOUND = 3'd4
   } status_type;

endpackage

`default_nettype wire

// ----- hw/rtl/bmhq_if.sv -----
// request, response and register-write channels of the heap queue
`timescale 1ns / 1ps
`default_nettype none

interface bmhq_req_if #(
   parameter int HANDLE_BITS = 16,
   parameter int KEY_BITS    = 16
);
   import bmhq_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [OP_BITS-1:0]     opcode;
   logic [HANDLE_BITS-1:0] handle;
   logic [KEY_BITS-1:0]    key;

   modport source (output valid, output opcode, output handle, output key, input ready);
   modport sink   (input valid, input opcode, input handle, input key, output ready);
endinterface

interface bmhq_rsp_if #(
   parameter int HANDLE_BITS = 16,
   parameter int KEY_BITS    = 16,
   parameter int COUNT_BITS  = 11
);
   import bmhq_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [STATUS_BITS-1:0] status;
   logic [HANDLE_BITS-1:0] out_handle;
   logic [KEY_BITS-1:0]    out_key;
   logic [COUNT_BITS-1:0]  member_count;

   modport source (output valid, output status, output out_handle, output out_key,
                   output member_count, input ready);
   modport sink   (input valid, input status, input out_handle, input out_key,
                   input member_count, output ready);
endinterface

interface bmhq_csr_if #(
   parameter int KEY_BITS = 16
);
   logic                valid;
   logic                ready;
   logic [KEY_BITS-1:0] insert_key_limit;

   modport source (output valid, output insert_key_limit, input ready);
   modport sink   (input valid, input insert_key_limit, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/binary_min_heap_queue.sv -----
// binary min-heap priority queue of (handle, key) entries in one on-chip memory
//
// req_chan takes one operation a beat: insert, pop minimum, update a handle's key, or nop.
// rsp_chan returns exactly one beat per request with status, popped entry and member count.
// csr_chan writes the insert key limit and is always ready; the user must write it only
// while idle, which the block does not enforce. One request is in flight at a time;
// req_chan is ready only when the sequencer is idle, and the result sits in an output
// register, so a new request is taken while it waits. Every step goes through the
// single heap memory (at most one read or one write a cycle, read data registered);
// the steps of each operation are:
//   drop, full, empty, no-op: straight to the response
//   insert: climb level by level while the new key is below its parent
//   pop:    read the root and the last entry, then sink the last entry from the root
//           unless the heap empties
//   update: scan from index 0 for the handle (not found after the member count), then
//           climb, or sink if it did not climb
// Reset empties the queue and sets the limit to all ones; the heap memory itself is not
// cleared, only entries below the member count are ever read. A stalled rsp_chan holds
// its beat, and the sequencer waits at the end of the next request until it is taken.
`timescale 1ns / 1ps
`default_nettype none

module binary_min_heap_queue #(
   parameter int CAPACITY    = bmhq_pkg::CAPACITY_DEF,
   parameter int KEY_BITS    = bmhq_pkg::KEY_BITS_DEF,
   parameter int HANDLE_BITS = bmhq_pkg::HANDLE_BITS_DEF
) (
   input wire logic   clock,
   input wire logic   reset,
   bmhq_req_if.sink   req_chan,
   bmhq_rsp_if.source rsp_chan,
   bmhq_csr_if.sink   csr_chan
);
   import bmhq_pkg::*;

   localparam int ADDR_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W   = $clog2(CAPACITY + 1);
   localparam int IDX_W   = ADDR_W + 2;
   localparam int ENTRY_W = HANDLE_BITS + KEY_BITS;

   // sequencer states
   typedef enum logic [10:0] {
      S_IDLE     = 11'b000_0000_0001,
      S_DECODE   = 11'b000_0000_0010,
      S_SCAN     = 11'b000_0000_0100,
      S_UP_RD    = 11'b000_0000_1000,
      S_UP_CMP   = 11'b000_0001_0000,
      S_POP_ROOT = 11'b000_0010_0000,
      S_POP_LAST = 11'b000_0100_0000,
      S_DN_RDL   = 11'b000_1000_0000,
      S_DN_RDR   = 11'b001_0000_0000,
      S_DN_CMP   = 11'b010_0000_0000,
      S_SEND     = 11'b100_0000_0000
   } state_type;

   // control registers
   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [KEY_BITS-1:0] limit_ff, limit_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // working registers
   op_type                 op_ff, op_in;
   logic [HANDLE_BITS-1:0] hdl_ff, hdl_in;
   logic [KEY_BITS-1:0]    key_ff, key_in;
   logic [ENTRY_W-1:0]     cur_ff, cur_in;
   logic [ENTRY_W-1:0]     lft_ff, lft_in;
   logic [ADDR_W-1:0]      pos_ff, pos_in;
   logic [CNT_W-1:0]       scan_ff, scan_in;
   logic [ADDR_W-1:0]      chk_idx_ff, chk_idx_in;
   logic                   chk_vld_ff, chk_vld_in;
   logic                   moved_ff, moved_in;
   logic                   rgt_vld_ff, rgt_vld_in;
   status_type             res_status_ff, res_status_in;
   logic [HANDLE_BITS-1:0] res_handle_ff, res_handle_in;
   logic [KEY_BITS-1:0]    res_key_ff, res_key_in;

   // output registers
   status_type             rsp_status_ff, rsp_status_in;
   logic [HANDLE_BITS-1:0] rsp_handle_ff, rsp_handle_in;
   logic [KEY_BITS-1:0]    rsp_key_ff, rsp_key_in;
   logic [CNT_W-1:0]       rsp_count_ff, rsp_count_in;

   // heap memory and its port
   logic [ENTRY_W-1:0] heap_mem_ff [CAPACITY];
   logic [ENTRY_W-1:0] rd_data_ff;
   logic               mem_re, mem_we;
   logic [ADDR_W-1:0]  mem_raddr, mem_waddr;
   logic [ENTRY_W-1:0] mem_wdata;

   // index arithmetic
   logic [ADDR_W-1:0]      pos_m1, parent_idx;
   logic [IDX_W-1:0]       left_w, right_w, count_w;
   logic [CNT_W-1:0]       count_m1;
   logic [KEY_BITS-1:0]    cur_key, rd_key, lft_key, best_key;
   logic [HANDLE_BITS-1:0] rd_handle;
   logic                   take_l, take_r, req_beat, rsp_beat;

   assign pos_m1     = pos_ff - 1'b1;
   assign parent_idx = ADDR_W'(pos_m1 >> 1);
   assign left_w     = {1'b0, pos_ff, 1'b1};
   assign right_w    = left_w + 1'b1;
   assign count_w    = IDX_W'(count_ff);
   assign count_m1   = count_ff - 1'b1;
   assign cur_key    = cur_ff[KEY_BITS-1:0];
   assign rd_key     = rd_data_ff[KEY_BITS-1:0];
   assign rd_handle  = rd_data_ff[ENTRY_W-1:KEY_BITS];
   assign lft_key    = lft_ff[KEY_BITS-1:0];

   // child selection: strict less-than, left wins a tie
   assign take_l   = lft_key < cur_key;
   assign best_key = take_l ? lft_key : cur_key;
   assign take_r   = rgt_vld_ff && (rd_key < best_key);

   // channel handshakes
   assign req_chan.ready = (state_ff == S_IDLE);
   assign csr_chan.ready = 1'b1;
   assign req_beat       = req_chan.valid && req_chan.ready;
   assign rsp_beat       = rsp_valid_ff && rsp_chan.ready;

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.out_handle   = rsp_handle_ff;
   assign rsp_chan.out_key      = rsp_key_ff;
   assign rsp_chan.member_count = rsp_count_ff;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      limit_in      = limit_ff;
      rsp_valid_in  = rsp_valid_ff;
      op_in         = op_ff;
      hdl_in        = hdl_ff;
      key_in        = key_ff;
      cur_in        = cur_ff;
      lft_in        = lft_ff;
      pos_in        = pos_ff;
      scan_in       = scan_ff;
      chk_idx_in    = chk_idx_ff;
      chk_vld_in    = chk_vld_ff;
      moved_in      = moved_ff;
      rgt_vld_in    = rgt_vld_ff;
      res_status_in = res_status_ff;
      res_handle_in = res_handle_ff;
      res_key_in    = res_key_ff;
      rsp_status_in = rsp_status_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_count_in  = rsp_count_ff;
      mem_re        = 1'b0;
      mem_raddr     = '0;
      mem_we        = 1'b0;
      mem_waddr     = pos_ff;
      mem_wdata     = cur_ff;

      // register write
      if (csr_chan.valid) begin
         limit_in = csr_chan.insert_key_limit;
      end

      // response beat taken
      if (rsp_beat) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               op_in    = op_type'(req_chan.opcode);
               hdl_in   = req_chan.handle;
               key_in   = req_chan.key;
               state_in = S_DECODE;
            end
         end

         S_DECODE: begin
            res_status_in = ST_OK;
            res_handle_in = '0;
            res_key_in    = '0;
            moved_in      = 1'b0;
            unique case (op_ff)
               OP_INSERT: begin
                  if (key_ff > limit_ff) begin
                     res_status_in = ST_DROPPED;
                     state_in      = S_SEND;
                  end else if (count_ff == CNT_W'(CAPACITY)) begin
                     res_status_in = ST_FULL;
                     state_in      = S_SEND;
                  end else begin
                     cur_in   = {hdl_ff, key_ff};
                     pos_in   = count_ff[ADDR_W-1:0];
                     count_in = count_ff + 1'b1;
                     state_in = S_UP_RD;
                  end
               end
               OP_POP: begin
                  if (count_ff == '0) begin
                     res_status_in = ST_EMPTY;
                     state_in      = S_SEND;
                  end else begin
                     mem_re    = 1'b1;
                     mem_raddr = '0;
                     state_in  = S_POP_ROOT;
                  end
               end
               OP_UPDATE: begin
                  scan_in    = '0;
                  chk_vld_in = 1'b0;
                  state_in   = S_SCAN;
               end
               default: begin
                  state_in = S_SEND;
               end
            endcase
         end

         // one entry read a cycle, its handle checked on the registered read data
         S_SCAN: begin
            if (chk_vld_ff && (rd_handle == hdl_ff)) begin
               cur_in   = {hdl_ff, key_ff};
               pos_in   = chk_idx_ff;
               state_in = S_UP_RD;
            end else if (scan_ff == count_ff) begin
               res_status_in = ST_NOT_FOUND;
               state_in      = S_SEND;
            end else begin
               mem_re     = 1'b1;
               mem_raddr  = scan_ff[ADDR_W-1:0];
               chk_idx_in = scan_ff[ADDR_W-1:0];
               chk_vld_in = 1'b1;
               scan_in    = scan_ff + 1'b1;
            end
         end

         // sift up: fetch parent; at the root settle, or sift down an unmoved update
         S_UP_RD: begin
            if (pos_ff == '0) begin
               if ((op_ff == OP_UPDATE) && !moved_ff) begin
                  state_in = S_DN_RDL;
               end else begin
                  mem_we   = 1'b1;
                  state_in = S_SEND;
               end
            end else begin
               mem_re    = 1'b1;
               mem_raddr = parent_idx;
               state_in  = S_UP_CMP;
            end
         end

         // sift up: parent moves down into the hole, the entry settles, or an unmoved update sifts down
         S_UP_CMP: begin
            if (cur_key < rd_key) begin
               mem_we    = 1'b1;
               mem_wdata = rd_data_ff;
               pos_in    = parent_idx;
               moved_in  = 1'b1;
               state_in  = S_UP_RD;
            end else if ((op_ff == OP_UPDATE) && !moved_ff) begin
               state_in = S_DN_RDL;
            end else begin
               mem_we   = 1'b1;
               state_in = S_SEND;
            end
         end

         // pop: capture root, fetch last entry
         S_POP_ROOT: begin
            res_handle_in = rd_handle;
            res_key_in    = rd_key;
            mem_re        = 1'b1;
            mem_raddr     = count_m1[ADDR_W-1:0];
            state_in      = S_POP_LAST;
         end

         S_POP_LAST: begin
            cur_in   = rd_data_ff;
            count_in = count_m1;
            pos_in   = '0;
            state_in = (count_m1 == '0) ? S_SEND : S_DN_RDL;
         end

         // sift down: fetch left child, or settle at a leaf
         S_DN_RDL: begin
            if (left_w >= count_w) begin
               mem_we   = 1'b1;
               state_in = S_SEND;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = left_w[ADDR_W-1:0];
               state_in  = S_DN_RDR;
            end
         end

         // sift down: keep left child, fetch right child
         S_DN_RDR: begin
            lft_in = rd_data_ff;
            if (right_w < count_w) begin
               mem_re     = 1'b1;
               mem_raddr  = right_w[ADDR_W-1:0];
               rgt_vld_in = 1'b1;
            end else begin
               rgt_vld_in = 1'b0;
            end
            state_in = S_DN_CMP;
         end

         // sift down: smaller child moves up into the hole or the entry settles
         S_DN_CMP: begin
            mem_we = 1'b1;
            if (take_r) begin
               mem_wdata = rd_data_ff;
               pos_in    = right_w[ADDR_W-1:0];
               state_in  = S_DN_RDL;
            end else if (take_l) begin
               mem_wdata = lft_ff;
               pos_in    = left_w[ADDR_W-1:0];
               state_in  = S_DN_RDL;
            end else begin
               state_in = S_SEND;
            end
         end

         // hand the result to the output register once it is free
         S_SEND: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_status_in = res_status_ff;
               rsp_handle_in = res_handle_ff;
               rsp_key_in    = res_key_ff;
               rsp_count_in  = count_ff;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         limit_ff     <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and output payload
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      hdl_ff        <= hdl_in;
      key_ff        <= key_in;
      cur_ff        <= cur_in;
      lft_ff        <= lft_in;
      pos_ff        <= pos_in;
      scan_ff       <= scan_in;
      chk_idx_ff    <= chk_idx_in;
      chk_vld_ff    <= chk_vld_in;
      moved_ff      <= moved_in;
      rgt_vld_ff    <= rgt_vld_in;
      res_status_ff <= res_status_in;
      res_handle_ff <= res_handle_in;
      res_key_ff    <= res_key_in;
      rsp_status_ff <= rsp_status_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // heap memory: one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         heap_mem_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= heap_mem_ff[mem_raddr];
      end
   end

   // one request in flight: no second request beat right after one
   a_single_request: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> !req_chan.ready)
      else $error("request taken while another is in flight");

   // writes stay inside the live part of the heap
   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (CNT_W'(mem_waddr) < count_ff))
      else $error("heap write beyond the member count");

   // a full report comes only with a full heap
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == ST_FULL)) |-> (rsp_count_ff == CNT_W'(CAPACITY)))
      else $error("full status with spare room");

   // only a successful pop carries an entry
   a_empty_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != ST_OK))
         |-> ((rsp_handle_ff == '0) && (rsp_key_ff == '0)))
      else $error("entry returned on a failed operation");

endmodule

`default_nettype wire
